### rtl/core/pdse_pkg.sv
package pdse_pkg;

    // Defaults for the top-level parameters
    localparam int STORE_WORDS_DEF = 4096;
    localparam int MAX_SPAN_DEF    = 64;

    // Width that holds any store index sum and the largest store size
    localparam int CMP_W    = 21;
    localparam int CURSOR_W = 7;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 8;

    // Item kinds carried on the input tuser
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_BEYOND = 2'd2;

    // Base code to ASCII letter
    localparam logic [6:0] LETTER_A = 7'd65;
    localparam logic [6:0] LETTER_C = 7'd67;
    localparam logic [6:0] LETTER_G = 7'd71;
    localparam logic [6:0] LETTER_T = 7'd84;

    typedef struct packed {
        logic load_wr;
        logic capture;
        logic fetch;
        logic emit;
        logic emit_err;
    } pdse_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic is_load;
        logic err;
        logic out_free;
        logic at_last;
        logic word_cross;
    } pdse_stat_t;

    function automatic logic [6:0] letter_of(input logic [1:0] code);
        logic [6:0] l;
        case (code)
            2'd0:    l = LETTER_A;
            2'd1:    l = LETTER_C;
            2'd2:    l = LETTER_G;
            default: l = LETTER_T;
        endcase
        return l;
    endfunction

endpackage

### rtl/core/pdse_ctrl.sv
module pdse_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdse_pkg::pdse_stat_t  stat,
    output pdse_pkg::pdse_cmd_t   cmd,
    output logic                  idle
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.in_fire)
                begin
                    if (stat.is_load)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (!stat.err)
                begin
                    state_next = S_FETCH;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.word_cross)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

`ifndef SYNTHESIS
    // A fetch always hands the fresh word straight to emission
    a_fetch_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> (state_reg == S_EMIT))
        else $error("fetch not followed by emit");

    // Final base of a run returns the controller to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.at_last) |=> idle)
        else $error("controller not idle after last base");

    // At most one datapath command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_wr, cmd.capture, cmd.fetch, cmd.emit, cmd.emit_err}))
        else $error("more than one command at once");
`endif

endmodule

### rtl/core/pdse_datapath.sv
module pdse_datapath #(
    parameter int STORE_WORDS = pdse_pkg::STORE_WORDS_DEF,
    parameter int MAX_SPAN    = pdse_pkg::MAX_SPAN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdse_pkg::pdse_cmd_t   cmd,
    output pdse_pkg::pdse_stat_t  stat,
    input  logic                  in_fire,
    input  logic                  mode,
    input  logic [11:0]           word_addr,
    input  logic [31:0]           word_data,
    input  logic [13:0]           seq_offset,
    input  logic [15:0]           range_start,
    input  logic [15:0]           range_end,
    input  logic                  reverse,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [6:0]            base,
    output logic                  last,
    output logic [1:0]            status
);

    localparam int ADDR_W = $clog2(STORE_WORDS);
    localparam int CMP_W  = pdse_pkg::CMP_W;
    localparam int CUR_W  = pdse_pkg::CURSOR_W;

    logic [31:0]       store [STORE_WORDS];
    logic [31:0]       rd_reg;

    logic [11:0]       first_word_reg;
    logic [15:0]       start_reg;
    logic [15:0]       end_reg;
    logic              rev_reg;
    logic [CUR_W-1:0]  cursor_reg;
    logic [CUR_W-1:0]  span_m1_reg;

    logic              out_valid_reg;
    logic [6:0]        base_reg;
    logic              last_reg;
    logic [1:0]        status_reg;

    logic [15:0]       diff;
    logic              bad_range;
    logic [CMP_W-1:0]  end_word;
    logic              beyond;
    logic [15:0]       pos;
    logic [CMP_W-1:0]  rd_idx;
    logic [CMP_W-1:0]  wr_idx;
    logic [4:0]        shamt;
    logic [31:0]       shifted;
    logic [1:0]        code;
    logic              out_free;

    // Range checks on the captured request
    assign diff      = end_reg - start_reg;
    assign bad_range = (end_reg < start_reg) || (diff >= 16'(MAX_SPAN));
    assign end_word  = CMP_W'(first_word_reg) + CMP_W'(end_reg[15:4]);
    assign beyond    = (end_word >= CMP_W'(STORE_WORDS));

    // Position of the base under the cursor, walking down when reversed
    assign pos     = rev_reg ? (end_reg - 16'(cursor_reg)) : (start_reg + 16'(cursor_reg));
    assign rd_idx  = CMP_W'(first_word_reg) + CMP_W'(pos[15:4]);
    assign wr_idx  = CMP_W'(word_addr);
    assign shamt   = {~pos[3:0], 1'b0};
    assign shifted = rd_reg >> shamt;
    assign code    = rev_reg ? ~shifted[1:0] : shifted[1:0];

    assign out_free = !out_valid_reg || out_ready;

    assign stat.in_fire    = in_fire;
    assign stat.is_load    = (mode == pdse_pkg::MODE_LOAD);
    assign stat.err        = bad_range || beyond;
    assign stat.out_free   = out_free;
    assign stat.at_last    = (cursor_reg == span_m1_reg);
    assign stat.word_cross = rev_reg ? (pos[3:0] == 4'h0) : (pos[3:0] == 4'hF);

    // Word store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && (wr_idx < CMP_W'(STORE_WORDS)))
        begin
            store[wr_idx[ADDR_W-1:0]] <= word_data;
        end
        if (cmd.fetch)
        begin
            rd_reg <= store[rd_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            first_word_reg <= seq_offset[13:2];
            start_reg      <= range_start;
            end_reg        <= range_end;
            rev_reg        <= reverse;
        end
        if (cmd.fetch)
        begin
            span_m1_reg <= CUR_W'(diff);
        end
        if (cmd.emit)
        begin
            base_reg   <= pdse_pkg::letter_of(code);
            last_reg   <= (cursor_reg == span_m1_reg);
            status_reg <= pdse_pkg::ST_OK;
        end
        else if (cmd.emit_err)
        begin
            base_reg   <= '0;
            last_reg   <= 1'b1;
            status_reg <= bad_range ? pdse_pkg::ST_RANGE : pdse_pkg::ST_BEYOND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                cursor_reg <= '0;
            end
            else if (cmd.emit)
            begin
                cursor_reg <= cursor_reg + CUR_W'(1);
            end
            if (cmd.emit || cmd.emit_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign base      = base_reg;
    assign last      = last_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // Cursor never walks past the end of the range
    a_cursor_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (cursor_reg <= span_m1_reg))
        else $error("cursor beyond span");

    // An error result is a single final word with a nonzero status
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_err |=> (out_valid_reg && last_reg && (status_reg != pdse_pkg::ST_OK)))
        else $error("bad error result");

    // Good results always carry one of the four letters
    a_letter: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.emit) |-> ((base_reg == pdse_pkg::LETTER_A) ||
                             (base_reg == pdse_pkg::LETTER_C) ||
                             (base_reg == pdse_pkg::LETTER_G) ||
                             (base_reg == pdse_pkg::LETTER_T)))
        else $error("base is not a letter");
`endif

endmodule

### rtl/core/packed_dna_subrange_extract.sv
// Packed DNA subrange extractor.
// Input stream (s_*): one word per item. s_tuser selects the kind: a load
// writes word_data (16 bases, 2 bits each, first base in bits 31:30) at
// word_addr; an extract names a sequence by its byte offset, an inclusive
// base range and a reverse flag.
// Output stream (m_*): one ASCII base per word, m_tlast on the final base of
// a run, m_tuser carries the status. A bad, inverted or too long range, or a
// range past the end of the store, gives a single word with base zero,
// m_tlast high and a nonzero status.
// Timing: a load is written to the store while the controller stays idle. An
// extract first runs the range checks, then does one store read for each store
// word the range touches (at most five for 64 bases) and emits its bases in
// order; the single read port of the store paces the run.
// One item is worked at a time; s_tready is high only while idle, but the
// last result word may still wait in the output register.
// If the receiver stalls, hold the output word and pause the run.
// Reset clears the controller and the output valid; the store is not
// cleared, and reading a word never written gives unspecified bases.
module packed_dna_subrange_extract #(
    parameter int STORE_WORDS = pdse_pkg::STORE_WORDS_DEF,
    parameter int MAX_SPAN    = pdse_pkg::MAX_SPAN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // word_addr[11:0], word_data[43:12], seq_offset[57:44],
    // range_start[73:58], range_end[89:74], reverse[90], zero fill above
    input  logic [pdse_pkg::IN_TDATA_W-1:0]     s_tdata,
    // mode[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // base[6:0], zero fill at bit 7
    output logic [pdse_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    // status[1:0]
    output logic [1:0]                          m_tuser
);

    pdse_pkg::pdse_cmd_t   cmd;
    pdse_pkg::pdse_stat_t  stat;
    logic                  idle;
    logic                  in_fire;
    logic [6:0]            base;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && idle;

    pdse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd),
        .idle  (idle)
    );

    pdse_datapath #(
        .STORE_WORDS (STORE_WORDS),
        .MAX_SPAN    (MAX_SPAN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_fire     (in_fire),
        .mode        (s_tuser),
        .word_addr   (s_tdata[11:0]),
        .word_data   (s_tdata[43:12]),
        .seq_offset  (s_tdata[57:44]),
        .range_start (s_tdata[73:58]),
        .range_end   (s_tdata[89:74]),
        .reverse     (s_tdata[90]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .base        (base),
        .last        (m_tlast),
        .status      (m_tuser)
    );

    // Pad the letter out to a whole byte
    assign m_tdata = {1'b0, base};

endmodule
